// File: hw/rtl/ftm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftm_pkg: types, constants and pipeline stage functions
// Beat types of both channels, the per-item context carried down the back
// pipeline, and the combinational work done in each back stage.
// ----------------------------------------------------------------------------
package ftm_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [16:0] ONE_Q16        = 17'd65536;
  localparam logic [15:0] HALF_Q16       = 16'd32768;
  localparam logic [27:0] TAU_RATIO_Q32  = 28'd197729557;
  localparam logic [15:0] SCORCH_EXP_Q16 = 16'd43713;
  localparam logic [40:0] EXP_CAP_Q16    = 41'd1099511627776;
  localparam logic [15:0] POLY_A         = 16'd45600;
  localparam logic [15:0] POLY_B         = 16'd14752;
  localparam logic [15:0] POLY_C         = 16'd5184;
  localparam logic [20:0] LOG_EIGHT      = 21'd524288;
  localparam logic [21:0] LOG_SIXTEEN    = 22'd1048576;

  // back pipeline stage map
  localparam int unsigned LOG_STEPS   = 16;
  localparam int unsigned DIV1_STEPS  = 16;
  localparam int unsigned DIV2_STEPS  = 17;
  localparam int unsigned POW_STEPS   = 5;
  localparam int unsigned ST_PREP     = 0;
  localparam int unsigned ST_LOGA     = 1;
  localparam int unsigned ST_TAU      = 1;
  localparam int unsigned ST_TAUP     = 2;
  localparam int unsigned ST_TAUR     = 3;
  localparam int unsigned ST_SHEXP    = ST_LOGA + LOG_STEPS;
  localparam int unsigned ST_SHMAG    = ST_SHEXP + 1;
  localparam int unsigned ST_POWA     = ST_SHMAG + 1;
  localparam int unsigned ST_SH       = ST_POWA + POW_STEPS;
  localparam int unsigned ST_REGION   = ST_SH + 1;
  localparam int unsigned ST_DIV1     = ST_REGION + 1;
  localparam int unsigned ST_PROD     = ST_DIV1 + DIV1_STEPS;
  localparam int unsigned ST_DIV2     = ST_PROD + 1;
  localparam int unsigned ST_CK       = ST_DIV2 + DIV2_STEPS;
  localparam int unsigned ST_CKNORM   = ST_CK + 1;
  localparam int unsigned ST_LOGB     = ST_CKNORM + 1;
  localparam int unsigned ST_LMC      = ST_LOGB + LOG_STEPS;
  localparam int unsigned ST_MAGP     = ST_LMC + 1;
  localparam int unsigned ST_MAG      = ST_MAGP + 1;
  localparam int unsigned ST_POWB     = ST_MAG + 1;
  localparam int unsigned ST_MORT     = ST_POWB + POW_STEPS;
  localparam int unsigned ST_KILL     = ST_MORT + 1;
  localparam int unsigned ST_NONC     = ST_KILL + 1;
  localparam int unsigned N_STAGES    = ST_NONC + 1;

  typedef struct packed {
    logic [23:0] bark_thickness;
    logic [23:0] tree_height;
    logic [16:0] crown_fraction;
    logic [19:0] scorch_factor;
    logic [25:0] surface_intensity;
    logic [23:0] fuel_sigma;
    logic [16:0] fire_fraction;
    logic [31:0] individuals;
  } ftm_in_t;

  typedef struct packed {
    logic [31:0] killed;
    logic [16:0] disturbed_fraction;
    logic [31:0] non_combusted;
  } ftm_out_t;

  typedef struct packed {
    logic    valid;
    ftm_in_t data;
  } ftm_push_t;

  typedef struct packed {
    ftm_in_t     x;
    logic [23:0] cl;
    logic [23:0] base;
    logic [31:0] b2;
    logic [35:0] t;
    logic [41:0] ph;
    logic [41:0] pl;
    logic [40:0] e;
    logic        small_exp;
    logic [32:0] nfa;
    logic [4:0]  lp;
    logic [30:0] lm;
    logic [15:0] lf;
    logic [21:0] lmc;
    logic        neg;
    logic [47:0] mag;
    logic [31:0] pq;
    logic [32:0] pright;
    logic [15:0] pf;
    logic [16:0] pv;
    logic [48:0] pres;
    logic [33:0] sh;
    logic        reg0;
    logic        reg2;
    logic [24:0] a;
    logic [25:0] b;
    logic [25:0] rem;
    logic [16:0] quo;
    logic [40:0] n2;
    logic [16:0] ck;
    logic [16:0] mort;
    logic [31:0] killed;
    logic [16:0] dist_frac;
    logic [31:0] nonc;
  } ftm_ctx_t;

  function automatic logic [4:0] ftm_msb(input logic [25:0] x);
    logic [4:0] p;
    begin
      p = '0;
      for (int i = 0; i < 26; i++) begin
        if (x[i]) p = 5'(i);
      end
      return p;
    end
  endfunction

  function automatic logic [30:0] ftm_norm(input logic [25:0] x, input logic [4:0] p);
    logic [56:0] w;
    begin
      w = 57'(x) << (5'd30 - p);
      return w[30:0];
    end
  endfunction

  function automatic ftm_ctx_t ftm_ctx_init(input ftm_in_t d);
    ftm_ctx_t n;
    begin
      n = '0;
      n.x = d;
      return n;
    end
  endfunction

  function automatic ftm_ctx_t ftm_stage(input int unsigned k, input ftm_ctx_t c);
    ftm_ctx_t    n;
    logic [61:0] sq;
    logic [31:0] mm;
    logic [20:0] lg;
    logic [60:0] rsum;
    logic [44:0] r;
    logic [44:0] rdiff;
    logic [26:0] rem2;
    logic [62:0] msum;
    logic [33:0] vprod;
    logic [16:0] vmul;
    logic [15:0] vadd;
    logic [5:0]  qq;
    logic [49:0] shp;
    logic [49:0] kp;
    logic [48:0] ncp;
    logic [33:0] sdiff;
    int unsigned j;
    begin
      n = c;
      lg = {c.lp, c.lf};
      j = 0;
      if (k == ST_PREP) begin
        n.cl  = 24'((41'(c.x.tree_height) * 41'(c.x.crown_fraction)) >> 16);
        n.b2  = 32'((48'(c.x.bark_thickness) * 48'(c.x.bark_thickness)) >> 16);
        n.nfa = 33'((49'(c.x.fire_fraction) * 49'(c.x.individuals)) >> 16);
        n.lp  = ftm_msb(c.x.surface_intensity);
        n.lm  = ftm_norm(c.x.surface_intensity, n.lp);
        n.lf  = '0;
      end
      if (k == ST_CKNORM) begin
        n.lp = ftm_msb(26'(c.ck));
        n.lm = ftm_norm(26'(c.ck), n.lp);
        n.lf = '0;
      end
      // one fraction bit of log2 per stage
      if (k inside {[ST_LOGA : ST_LOGA + LOG_STEPS - 1], [ST_LOGB : ST_LOGB + LOG_STEPS - 1]})
      begin
        sq = 62'(c.lm) * 62'(c.lm);
        mm = 32'(sq >> 30);
        if (mm[31]) begin
          n.lm = mm[31:1];
          n.lf = {c.lf[14:0], 1'b1};
        end else begin
          n.lm = mm[30:0];
          n.lf = {c.lf[14:0], 1'b0};
        end
      end
      if (k == ST_TAU) begin
        n.base = c.x.tree_height - c.cl;
        n.t    = 36'((60'(c.b2) * 60'(TAU_RATIO_Q32)) >> 24);
      end
      if (k == ST_TAUP) begin
        n.ph = 42'(c.t[35:18]) * 42'(c.x.fuel_sigma);
        n.pl = 42'(c.t[17:0]) * 42'(c.x.fuel_sigma);
      end
      if (k == ST_TAUR) begin
        rsum        = (61'(c.ph) << 18) + 61'(c.pl);
        r           = 45'(rsum >> 16);
        rdiff       = r - 45'(HALF_Q16);
        n.small_exp = r <= 45'(HALF_Q16);
        if (n.small_exp) begin
          n.e = '0;
        end else if (rdiff > 45'(EXP_CAP_Q16)) begin
          n.e = EXP_CAP_Q16;
        end else begin
          n.e = 41'(rdiff);
        end
      end
      if (k == ST_SHEXP) begin
        n.neg = lg < LOG_EIGHT;
        n.lmc = n.neg ? 22'(LOG_EIGHT - lg) : 22'(lg - LOG_EIGHT);
      end
      if (k == ST_SHMAG) begin
        n.mag = 48'((38'(c.lmc) * 38'(SCORCH_EXP_Q16)) >> 16);
      end
      if (k inside {[ST_POWA : ST_POWA + POW_STEPS - 1], [ST_POWB : ST_POWB + POW_STEPS - 1]})
      begin
        j = (k >= ST_POWB) ? (k - ST_POWB) : (k - ST_POWA);
        if (j == 0) begin
          n.pq = c.mag[47:16];
          if (!c.neg) begin
            n.pf     = c.mag[15:0];
            n.pright = '0;
          end else if (c.mag[15:0] == '0) begin
            n.pf     = '0;
            n.pright = 33'(c.mag[47:16]);
          end else begin
            n.pf     = 16'(ONE_Q16 - 17'(c.mag[15:0]));
            n.pright = 33'(c.mag[47:16]) + 33'd1;
          end
        end else if (j < POW_STEPS - 1) begin
          vmul  = (j == 1) ? 17'(POLY_C) : c.pv;
          vadd  = (j == 1) ? POLY_B : POLY_A;
          vprod = 34'(vmul) * 34'(c.pf);
          if (j == POW_STEPS - 2) begin
            n.pv = 17'(18'(ONE_Q16) + 18'(vprod >> 16));
          end else begin
            n.pv = 17'(18'(vadd) + 18'(vprod >> 16));
          end
        end else begin
          if (!c.neg) begin
            qq     = (c.pq > 32'd32) ? 6'd32 : 6'(c.pq);
            n.pres = 49'(c.pv) << qq;
          end else if (c.pright >= 33'd63) begin
            n.pres = '0;
          end else begin
            n.pres = 49'(c.pv) >> c.pright[5:0];
          end
        end
      end
      if (k == ST_SH) begin
        shp  = 50'(c.x.scorch_factor) * 50'(c.pres[29:0]);
        n.sh = (c.x.surface_intensity == '0) ? '0 : 34'(shp >> 16);
      end
      if (k == ST_REGION) begin
        n.reg0 = c.sh < 34'(c.base);
        n.reg2 = !n.reg0 && (c.sh >= 34'(c.x.tree_height));
        n.a    = 25'(c.sh - 34'(c.base));
        sdiff  = 34'(c.x.tree_height) - c.sh + 34'(c.cl);
        n.b    = 26'(sdiff);
        n.rem  = 26'(n.a);
        n.quo  = '0;
      end
      if (k inside {[ST_DIV1 : ST_DIV1 + DIV1_STEPS - 1], [ST_DIV2 : ST_DIV2 + DIV2_STEPS - 1]})
      begin
        if (k >= ST_DIV2) begin
          rem2 = {c.rem, c.n2[6'(ST_DIV2 + DIV2_STEPS - 1 - k)]};
        end else begin
          rem2 = {c.rem, 1'b0};
        end
        if (rem2 >= 27'(c.cl)) begin
          n.rem = 26'(rem2 - 27'(c.cl));
          n.quo = {c.quo[15:0], 1'b1};
        end else begin
          n.rem = 26'(rem2);
          n.quo = {c.quo[15:0], 1'b0};
        end
      end
      if (k == ST_PROD) begin
        n.n2  = 41'(c.quo[15:0]) * 41'(c.b);
        n.rem = 26'(n.n2 >> 17);
        n.quo = '0;
      end
      if (k == ST_CK) begin
        if (c.reg0) begin
          n.ck = '0;
        end else if (c.reg2 || (c.quo > ONE_Q16)) begin
          n.ck = ONE_Q16;
        end else begin
          n.ck = c.quo;
        end
      end
      if (k == ST_LMC) begin
        n.lmc = LOG_SIXTEEN - 22'(lg);
      end
      if (k == ST_MAGP) begin
        n.ph = 42'(c.lmc[20:0]) * 42'(c.e[40:20]);
        n.pl = 42'(c.lmc[20:0]) * 42'(c.e[19:0]);
      end
      if (k == ST_MAG) begin
        msum  = (63'(c.ph) << 20) + 63'(c.pl);
        n.mag = 48'(msum >> 16);
        n.neg = 1'b1;
      end
      if (k == ST_MORT) begin
        if ((c.x.fuel_sigma == '0) || (c.ck == '0)) begin
          n.mort = '0;
        end else if ((c.ck >= ONE_Q16) || c.small_exp || (c.pres > 49'(ONE_Q16))) begin
          n.mort = ONE_Q16;
        end else begin
          n.mort = 17'(c.pres);
        end
      end
      if (k == ST_KILL) begin
        kp          = 50'(c.mort) * 50'(c.nfa);
        n.killed    = 32'(kp >> 16);
        n.dist_frac = 17'((34'(c.x.fire_fraction) * 34'(c.ck)) >> 16);
      end
      if (k == ST_NONC) begin
        ncp    = 49'(c.killed) * 49'(ONE_Q16 - c.ck);
        n.nonc = 32'(ncp >> 16);
      end
      return n;
    end
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ftm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftm_front: input acceptance
// Takes input beats while the queue has room and saturates both fractions
// to one before queuing.
// ----------------------------------------------------------------------------
module ftm_front (
  input  wire logic             in_valid_i,
  input  wire ftm_pkg::ftm_in_t in_data_i,
  output logic                  in_stall_o,
  input  wire logic             q_full_i,
  output ftm_pkg::ftm_push_t    push_o
);

  ftm_pkg::ftm_in_t sat;

  always_comb begin
    sat = in_data_i;
    if (in_data_i.crown_fraction > ftm_pkg::ONE_Q16) sat.crown_fraction = ftm_pkg::ONE_Q16;
    if (in_data_i.fire_fraction > ftm_pkg::ONE_Q16) sat.fire_fraction = ftm_pkg::ONE_Q16;
  end

  assign in_stall_o   = q_full_i;
  assign push_o.valid = in_valid_i && !q_full_i;
  assign push_o.data  = sat;

endmodule
`default_nettype wire

// File: hw/rtl/ftm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftm_queue: item queue
// Short FIFO between the front and the back pipeline.
// ----------------------------------------------------------------------------
module ftm_queue #(
  parameter int unsigned Depth = ftm_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ftm_pkg::ftm_push_t push_i,
  output logic                    full_o,
  output logic                    valid_o,
  output ftm_pkg::ftm_in_t        data_o,
  input  wire logic               pop_i
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  ftm_pkg::ftm_in_t entries_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign push    = push_i.valid;
  assign pop     = pop_i && (cnt_q != '0);
  assign full_o  = cnt_q == CW'(Depth);
  assign valid_o = cnt_q != '0;
  assign data_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (pop) rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    if (push && !pop) cnt_d = cnt_q + 1'b1;
    else if (pop && !push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entries_q[wr_ptr_q] <= push_i.data;
  end

endmodule
`default_nettype wire

// File: hw/rtl/ftm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftm_back: mortality pipeline
// Fixed-depth pipeline: log2 by squaring, exp2 by polynomial, crown kill by
// restoring division, one step per stage. Last stage is the output register.
// ----------------------------------------------------------------------------
module ftm_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire ftm_pkg::ftm_in_t q_data_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  output ftm_pkg::ftm_out_t     out_data_o,
  input  wire logic             out_stall_i
);

  localparam int unsigned N = ftm_pkg::N_STAGES;

  ftm_pkg::ftm_ctx_t stage_in [N];
  ftm_pkg::ftm_ctx_t ctx_q [N];
  logic [N-1:0] vld_in;
  logic [N-1:0] vld_q;
  logic adv;

  assign adv         = !(vld_q[N-1] && out_stall_i);
  assign pop_o       = adv && q_valid_i;
  assign stage_in[0] = ftm_pkg::ftm_ctx_init(q_data_i);
  assign vld_in[0]   = q_valid_i;

  for (genvar g = 0; g < N; g++) begin : g_stage
    if (g > 0) begin : g_link
      assign stage_in[g] = ctx_q[g-1];
      assign vld_in[g]   = vld_q[g-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (adv) begin
        vld_q[g] <= vld_in[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) ctx_q[g] <= ftm_pkg::ftm_stage(32'(g), stage_in[g]);
    end
  end

  assign out_valid_o                   = vld_q[N-1];
  assign out_data_o.killed             = ctx_q[N-1].killed;
  assign out_data_o.disturbed_fraction = ctx_q[N-1].dist_frac;
  assign out_data_o.non_combusted      = ctx_q[N-1].nonc;

endmodule
`default_nettype wire

// File: hw/rtl/fire_tree_mortality.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fire_tree_mortality: stand fire mortality engine
// Path: the input beat goes through the queue, then the 89-stage back pipeline to the result beat.
// Throughput: one beat per cycle while the output is not stalled; the 89-stage back pipeline sets the depth.
// An output stall with a result waiting freezes the back pipeline; the front keeps filling the queue until full.
// Reset clears the queue and all stage valids; no clearing pass.
// ----------------------------------------------------------------------------
module fire_tree_mortality #(
  parameter int unsigned QueueDepth = ftm_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire ftm_pkg::ftm_in_t in_data_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  output ftm_pkg::ftm_out_t     out_data_o,
  input  wire logic             out_stall_i
);

  ftm_pkg::ftm_push_t push;
  ftm_pkg::ftm_in_t   q_data;
  logic q_full, q_valid, pop;

  ftm_front u_front (
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  ftm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (pop)
  );

  ftm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
`default_nettype wire
